FILE: src/q2e_pkg.sv
// package: constants, types and arctangent table for the quaternion to euler block
package q2e_pkg;

	localparam int CordicStepsDef = 14;
	localparam int DataW = 16;
	localparam int SumW = 36;
	localparam int CordW = 40;
	localparam int AngW = 28;
	localparam int RootW = 30;
	localparam int RadW = 58;
	localparam int PitchW = 15;

	localparam logic signed [AngW-1:0] AngPi = AngW'(52707179);
	localparam logic signed [AngW-1:0] AngHalfPi = AngW'(26353589);
	localparam logic signed [SumW-1:0] OneQ28 = SumW'(64'sd268435456);
	localparam int RollLimit = 25736;
	localparam int PitchLimit = 12868;

	typedef logic signed [CordW-1:0] cord_t;
	typedef logic signed [AngW-1:0] ang_t;

	function automatic ang_t atan_tab(input logic [4:0] idx);
		ang_t r;
		case (idx)
			5'd0: r = AngW'(13176795);
			5'd1: r = AngW'(7778716);
			5'd2: r = AngW'(4110060);
			5'd3: r = AngW'(2086331);
			5'd4: r = AngW'(1047214);
			5'd5: r = AngW'(524117);
			5'd6: r = AngW'(262123);
			5'd7: r = AngW'(131069);
			5'd8: r = AngW'(65536);
			5'd9: r = AngW'(32768);
			5'd10: r = AngW'(16384);
			5'd11: r = AngW'(8192);
			5'd12: r = AngW'(4096);
			5'd13: r = AngW'(2048);
			5'd14: r = AngW'(1024);
			5'd15: r = AngW'(512);
			5'd16: r = AngW'(256);
			5'd17: r = AngW'(128);
			5'd18: r = AngW'(64);
			5'd19: r = AngW'(32);
			5'd20: r = AngW'(16);
			5'd21: r = AngW'(8);
			5'd22: r = AngW'(4);
			5'd23: r = AngW'(2);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/q2e_cordic.sv
// pipelined vectoring cordic, three atan2 lanes, one micro-rotation per stage
module q2e_cordic #(
	parameter int CORDIC_STEPS = q2e_pkg::CordicStepsDef,
	parameter int TAG_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [TAG_W-1:0] in_tag,
	input  q2e_pkg::cord_t in_y [3],
	input  q2e_pkg::cord_t in_x [3],
	output logic out_valid,
	output logic [TAG_W-1:0] out_tag,
	output q2e_pkg::ang_t out_ang [3]
);
	localparam int N = CORDIC_STEPS + 1;

	logic vld_s1 [N];
	logic [TAG_W-1:0] tag_s1 [N];
	q2e_pkg::cord_t x_s1 [N][3];
	q2e_pkg::cord_t y_s1 [N][3];
	q2e_pkg::ang_t z_s1 [N][3];

	// pre-rotation into the right half plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1[0] <= 1'b0;
		end else if (en) begin
			vld_s1[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1[0] <= in_tag;
			for (int l = 0; l < 3; l++) begin
				if (in_x[l] < 0) begin
					x_s1[0][l] <= -in_x[l];
					y_s1[0][l] <= -in_y[l];
					z_s1[0][l] <= (in_y[l] >= 0) ? q2e_pkg::AngPi : -q2e_pkg::AngPi;
				end else begin
					x_s1[0][l] <= in_x[l];
					y_s1[0][l] <= in_y[l];
					z_s1[0][l] <= (in_x[l] == 0 && in_y[l] == 0) ? '0 : '0;
				end
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[i+1] <= 1'b0;
			end else if (en) begin
				vld_s1[i+1] <= vld_s1[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				tag_s1[i+1] <= tag_s1[i];
				for (int l = 0; l < 3; l++) begin
					if (x_s1[i][l] == 0 && y_s1[i][l] == 0) begin
						x_s1[i+1][l] <= '0;
						y_s1[i+1][l] <= '0;
						z_s1[i+1][l] <= z_s1[i][l];
					end else if (y_s1[i][l] >= 0) begin
						x_s1[i+1][l] <= x_s1[i][l] + (y_s1[i][l] >>> i);
						y_s1[i+1][l] <= y_s1[i][l] - (x_s1[i][l] >>> i);
						z_s1[i+1][l] <= z_s1[i][l] + q2e_pkg::atan_tab(5'(i));
					end else begin
						x_s1[i+1][l] <= x_s1[i][l] - (y_s1[i][l] >>> i);
						y_s1[i+1][l] <= y_s1[i][l] + (x_s1[i][l] >>> i);
						z_s1[i+1][l] <= z_s1[i][l] - q2e_pkg::atan_tab(5'(i));
					end
				end
			end
		end
	end

	assign out_valid = vld_s1[N-1];
	assign out_tag = tag_s1[N-1];
	assign out_ang = z_s1[N-1];
endmodule

FILE: src/quaternion_to_euler.sv
// top level: quaternion to roll, pitch, yaw with product, sum, clamp, root, cordic and rounding stages
// 3 front stages (products, sums, clamp), 29 root stages, CORDIC_STEPS+1 cordic stages and
// 1 output register
// throughput: one transfer per cycle, the whole pipeline advances when the output is free
// the square root is one result bit per stage, set by the 29-bit root width
// reset clears the valid bits only, payload registers are not reset
module quaternion_to_euler #(
	parameter int CORDIC_STEPS = q2e_pkg::CordicStepsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [63:0] s_axis_tdata, // quat_w, quat_x, quat_y, quat_z
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [47:0] m_axis_tdata, // roll_angle, pitch_angle, yaw_angle
	output logic m_axis_tuser // pitch_clamped
);
	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: products
	logic v_s1, v_s2, v_s3;
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, xz_s1, wz_s1, xy_s1, zz_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		logic signed [15:0] w, x, y, z;
		w = s_axis_tdata[15:0];
		x = s_axis_tdata[31:16];
		y = s_axis_tdata[47:32];
		z = s_axis_tdata[63:48];
		if (en) begin
			wx_s1 <= w * x;
			yz_s1 <= y * z;
			xx_s1 <= x * x;
			yy_s1 <= y * y;
			wy_s1 <= w * y;
			xz_s1 <= x * z;
			wz_s1 <= w * z;
			xy_s1 <= x * y;
			zz_s1 <= z * z;
		end
	end

	// stage 2: sums
	logic signed [35:0] sr_s2, cr_s2, sy_s2, cy_s2, a_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			sr_s2 <= 36'(wx_s1) + 36'(yz_s1) <<< 1;
			cr_s2 <= q2e_pkg::OneQ28 - ((36'(xx_s1) + 36'(yy_s1)) <<< 1);
			sy_s2 <= (36'(wz_s1) + 36'(xy_s1)) <<< 1;
			cy_s2 <= q2e_pkg::OneQ28 - ((36'(yy_s1) + 36'(zz_s1)) <<< 1);
			a_s2 <= (36'(wy_s1) - 36'(xz_s1)) <<< 1;
		end
	end

	// stage 3: clamp and root operands
	logic signed [35:0] sr_s3, cr_s3, sy_s3, cy_s3;
	logic [29:0] pa_s3, pb_s3;
	logic clamp_s3;
	always_ff @(posedge clk) begin
		logic signed [35:0] a;
		a = a_s2;
		if (a > q2e_pkg::OneQ28) a = q2e_pkg::OneQ28;
		if (a < -q2e_pkg::OneQ28) a = -q2e_pkg::OneQ28;
		if (en) begin
			sr_s3 <= sr_s2;
			cr_s3 <= cr_s2;
			sy_s3 <= sy_s2;
			cy_s3 <= cy_s2;
			pa_s3 <= 30'(q2e_pkg::OneQ28 + a);
			pb_s3 <= 30'(q2e_pkg::OneQ28 - a);
			clamp_s3 <= (a_s2 > q2e_pkg::OneQ28) || (a_s2 < -q2e_pkg::OneQ28);
		end
	end

	// square roots of v*2^28, one result bit per stage (radicand 58 bits, root 29 bits)
	// operand n = v<<28; root bits from high to low, RS+... handled over 29 stages of 1 bit
	localparam int NB = 29;
	logic rv_s [NB+1];
	logic [57:0] ra_rem [NB+1], rb_rem [NB+1];
	logic [28:0] ra_res [NB+1], rb_res [NB+1];
	logic signed [35:0] rsr [NB+1], rcr [NB+1], rsy [NB+1], rcy [NB+1];
	logic rcl [NB+1];

	always_comb begin
		rv_s[0] = v_s3;
		ra_rem[0] = {pa_s3[29:0], 28'd0};
		rb_rem[0] = {pb_s3[29:0], 28'd0};
		ra_res[0] = '0;
		rb_res[0] = '0;
		rsr[0] = sr_s3;
		rcr[0] = cr_s3;
		rsy[0] = sy_s3;
		rcy[0] = cy_s3;
		rcl[0] = clamp_s3;
	end

	for (genvar k = 0; k < NB; k++) begin : g_root
		localparam int B = NB - 1 - k;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s[k+1] <= 1'b0;
			end else if (en) begin
				rv_s[k+1] <= rv_s[k];
			end
		end
		always_ff @(posedge clk) begin
			logic [59:0] ta, tb;
			ta = ({2'b0, ra_res[k]} << (B + 1)) + (60'd1 << (2 * B));
			tb = ({2'b0, rb_res[k]} << (B + 1)) + (60'd1 << (2 * B));
			if (en) begin
				if ({2'b0, ra_rem[k]} >= ta) begin
					ra_rem[k+1] <= 58'({2'b0, ra_rem[k]} - ta);
					ra_res[k+1] <= ra_res[k] | (29'd1 << B);
				end else begin
					ra_rem[k+1] <= ra_rem[k];
					ra_res[k+1] <= ra_res[k];
				end
				if ({2'b0, rb_rem[k]} >= tb) begin
					rb_rem[k+1] <= 58'({2'b0, rb_rem[k]} - tb);
					rb_res[k+1] <= rb_res[k] | (29'd1 << B);
				end else begin
					rb_rem[k+1] <= rb_rem[k];
					rb_res[k+1] <= rb_res[k];
				end
				rsr[k+1] <= rsr[k];
				rcr[k+1] <= rcr[k];
				rsy[k+1] <= rsy[k];
				rcy[k+1] <= rcy[k];
				rcl[k+1] <= rcl[k];
			end
		end
	end

	q2e_pkg::cord_t cy_in [3], cx_in [3];
	q2e_pkg::ang_t ang [3];
	logic cv, ctag;
	assign cy_in[0] = q2e_pkg::CordW'(rsr[NB]);
	assign cx_in[0] = q2e_pkg::CordW'(rcr[NB]);
	assign cy_in[1] = q2e_pkg::CordW'({1'b0, ra_res[NB]});
	assign cx_in[1] = q2e_pkg::CordW'({1'b0, rb_res[NB]});
	assign cy_in[2] = q2e_pkg::CordW'(rsy[NB]);
	assign cx_in[2] = q2e_pkg::CordW'(rcy[NB]);

	q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .TAG_W(1)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(rv_s[NB]), .in_tag(rcl[NB]), .in_y(cy_in), .in_x(cx_in),
		.out_valid(cv), .out_tag(ctag), .out_ang(ang)
	);

	function automatic logic signed [15:0] to_q13(input logic signed [29:0] a, input int lim);
		logic signed [29:0] r;
		r = (a + 30'sd1024) >>> 11;
		if (r > 30'(lim)) r = 30'(lim);
		if (r < -30'(lim)) r = -30'(lim);
		return r[15:0];
	endfunction

	logic signed [15:0] roll_q, yaw_q, pitch_full;
	logic clamp_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= cv;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			roll_q <= to_q13(30'(ang[0]), q2e_pkg::RollLimit);
			yaw_q <= to_q13(30'(ang[2]), q2e_pkg::RollLimit);
			pitch_full <= to_q13((30'(ang[1]) <<< 1) - 30'(q2e_pkg::AngHalfPi),
				q2e_pkg::PitchLimit);
			clamp_q <= ctag;
		end
	end

	assign m_axis_tdata = {1'b0, yaw_q, pitch_full[14:0], roll_q};
	assign m_axis_tuser = clamp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pitch_full <= 16'sd12868 && pitch_full >= -16'sd12868)
		else $error("pitch out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("ready not tied to output stage");
endmodule

FILE: dv/quaternion_to_euler_test.sv
// testbench: quaternion to euler angles, checked against an in-bench predictor
`timescale 1ns / 1ps

module quaternion_to_euler_test;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic clamped;
	} euler_t;

	localparam longint PiQ24 = 64'sd52707179;
	localparam longint HalfPiQ24 = 64'sd26353589;
	localparam longint UnitQ28 = 64'sd268435456;
	localparam longint ArctanQ24 [24] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	logic clk;
	logic arst_n;
	logic s_valid;
	logic s_ready;
	logic [63:0] s_data;
	logic m_valid;
	logic m_ready = 1'b0;
	logic [47:0] m_data;
	logic m_user;

	euler_t angles_due [$];
	int mismatches = 0;
	int hold_left = 0;
	bit idle_on = 1'b1;

	quaternion_to_euler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_ready),
		.s_axis_tdata(s_data),
		.m_axis_tvalid(m_valid),
		.m_axis_tready(m_ready),
		.m_axis_tdata(m_data),
		.m_axis_tuser(m_user)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic longint vector_angle(longint yv, longint xv);
		longint acc;
		longint dx;
		longint dy;
		acc = 0;
		if (xv == 0 && yv == 0)
			return 0;
		if (xv < 0) begin
			acc = (yv >= 0) ? PiQ24 : -PiQ24;
			xv = -xv;
			yv = -yv;
		end
		for (int i = 0; i < q2e_pkg::CordicStepsDef && i < 24; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv >= 0) begin
				xv += dx;
				yv -= dy;
				acc += ArctanQ24[i];
			end else begin
				xv -= dx;
				yv += dy;
				acc -= ArctanQ24[i];
			end
		end
		return acc;
	endfunction

	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint round_q13(longint a, longint lim);
		longint r;
		r = (a + 1024) >>> 11;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic euler_t predict_angles(logic [63:0] q);
		longint w;
		longint x;
		longint y;
		longint z;
		longint t2;
		longint unsigned sp;
		longint unsigned cp;
		euler_t e;
		w = longint'($signed(q[15:0]));
		x = longint'($signed(q[31:16]));
		y = longint'($signed(q[47:32]));
		z = longint'($signed(q[63:48]));
		e.roll = 16'(round_q13(vector_angle(2 * (w * x + y * z),
			UnitQ28 - 2 * (x * x + y * y)), q2e_pkg::RollLimit));
		t2 = 2 * (w * y - x * z);
		e.clamped = 1'b0;
		if (t2 > UnitQ28) begin
			t2 = UnitQ28;
			e.clamped = 1'b1;
		end else if (t2 < -UnitQ28) begin
			t2 = -UnitQ28;
			e.clamped = 1'b1;
		end
		sp = int_root(longint'(UnitQ28 + t2) << 28);
		cp = int_root(longint'(UnitQ28 - t2) << 28);
		e.pitch = 15'(round_q13(2 * vector_angle(longint'(sp), longint'(cp)) - HalfPiQ24,
			q2e_pkg::PitchLimit));
		e.yaw = 16'(round_q13(vector_angle(2 * (w * z + x * y),
			UnitQ28 - 2 * (y * y + z * z)), q2e_pkg::RollLimit));
		return e;
	endfunction

	task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		logic [63:0] q;
		q = {z, y, x, w};
		while (idle_on && $urandom_range(99) < 9) begin
			s_valid <= 1'b0;
			@(posedge clk);
		end
		s_valid <= 1'b1;
		s_data <= q;
		@(posedge clk);
		while (!s_ready)
			@(posedge clk);
		angles_due = {angles_due, predict_angles(q)};
	endtask

	task automatic send_unit_quat(int spread);
		real c [4];
		real n;
		logic [15:0] v [4];
		n = 0.0;
		for (int i = 0; i < 4; i++) begin
			c[i] = real'(int'($urandom_range(2000)) - 1000);
			if ($urandom_range(9) == 0)
				c[i] = 0.0;
			n += c[i] * c[i];
		end
		if (n == 0.0) begin
			c[0] = 1.0;
			n = 1.0;
		end
		n = $sqrt(n);
		for (int i = 0; i < 4; i++)
			v[i] = 16'(int'(c[i] / n * 16384.0) + int'($urandom_range(2 * spread)) - spread);
		send_quat(v[0], v[1], v[2], v[3]);
	endtask

	task automatic wait_drained();
		int n;
		n = 0;
		while (angles_due.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		if (angles_due.size() != 0) begin
			$display("quaternion_to_euler_test: errors");
			$finish;
		end
	endtask

	task automatic test_directed();
		send_quat(16'sd16384, 0, 0, 0);
		send_quat(-16'sd16384, 0, 0, 0);
		send_quat(0, 0, 0, 0);
		send_quat(0, 16'sd16384, 0, 0);
		send_quat(0, 0, 16'sd16384, 0);
		send_quat(0, 0, 0, 16'sd16384);
		send_quat(0, -16'sd16384, 0, 0);
		send_quat(0, 0, -16'sd16384, 0);
		send_quat(0, 0, 0, -16'sd16384);
		send_quat(16'sd11585, 0, 16'sd11585, 0);
		send_quat(16'sd11585, 0, -16'sd11585, 0);
		send_quat(16'sd11586, 0, 16'sd11586, 0);
		send_quat(16'sd11586, 16'sd11586, 0, -16'sd11586);
		send_quat(16'sd16384, 0, 16'sd16384, 0);
		send_quat(16'sd16384, 0, -16'sd16384, 0);
		send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
		send_quat(16'sd11585, 16'sd11585, 0, 0);
		send_quat(16'sd100, 16'sd16000, 16'sd20, -16'sd3000);
		send_quat(0, 16'sd11585, 0, 16'sd11585);
	endtask

	task automatic test_random(int count);
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(19))
				0, 1: send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				2, 3: send_quat(16'($urandom_range(32768) - 16384),
					16'($urandom_range(32768) - 16384),
					16'($urandom_range(32768) - 16384),
					16'($urandom_range(32768) - 16384));
				4: send_unit_quat(40);
				default: send_unit_quat(2);
			endcase
		end
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_left = 300;
		test_random(120);
		idle_on = 1'b1;
		s_valid <= 1'b0;
		wait_drained();
	endtask

	task automatic test_steady();
		idle_on = 1'b0;
		test_random(200);
		idle_on = 1'b1;
	endtask

	always @(posedge clk) begin
		euler_t got;
		euler_t due;
		if (m_valid && m_ready) begin
			got = {m_data[15:0], m_data[30:16], m_data[46:31], m_user};
			if (angles_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: %h", m_data);
			end else begin
				due = angles_due.pop_front();
				if (got.roll !== due.roll || got.pitch !== due.pitch ||
						got.yaw !== due.yaw || got.clamped !== due.clamped ||
						m_data[47] !== 1'b0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d clamp %b/%b",
							due.roll, got.roll, due.pitch, got.pitch, due.yaw, got.yaw,
							due.clamped, got.clamped);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_ready <= 1'b0;
		end else begin
			m_ready <= !(idle_on && $urandom_range(99) < 9);
		end
	end

	initial begin
		#2ms;
		$display("quaternion_to_euler_test: errors");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_valid <= 1'b0;
		s_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500);
		s_valid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		test_backpressure();
		test_steady();
		test_random(500);
		s_valid <= 1'b0;
		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("quaternion_to_euler_test: clean");
		else
			$display("quaternion_to_euler_test: errors");
		$finish;
	end

endmodule
